[rtl/backspace_overstrike_converter_core_macros.svh]
// Assertion macros used by the converter RTL.
`ifndef BACKSPACE_OVERSTRIKE_CONVERTER_CORE_MACROS_SVH
`define BACKSPACE_OVERSTRIKE_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BSOC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BSOC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsoc_pkg.sv]
package bsoc_pkg;

    // Highest print column; the column counter saturates here.
    localparam logic [7:0] COLUMN_LIMIT = 8'd255;

    localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;
    localparam int unsigned MAX_ITEMS = 4;
    localparam int unsigned SLOT_W = 2;

    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_END     = 8'h1A;
    localparam logic [7:0] CTL_SKIP   = 8'h20;
    localparam logic [7:0] CTL_NOSKIP = 8'h2B;
    localparam logic [7:0] CTL_FORM   = 8'h31;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_count;
    } item_t;

    // One command holds every result of one input byte, packed from slot 0.
    typedef struct packed {
        logic [SLOT_W-1:0] last_slot;
        item_t [MAX_ITEMS-1:0] items;
    } cmd_t;

    // Carriage-control translation of one emitted byte.
    function automatic logic [7:0] translate(input logic [7:0] b, input logic rp);
        logic [7:0] r;
        r = b;
        if (rp) begin
            if (b == CH_LF || b == CTL_SKIP) begin
                r = CH_LF;
            end else if (b == CTL_NOSKIP) begin
                r = CH_CR;
            end else if (b == CTL_FORM) begin
                r = CH_FF;
            end
        end else if (b == CH_LF) begin
            r = CH_CR;
        end
        return r;
    endfunction

endpackage

[rtl/bsoc_front.sv]
module bsoc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_end_of_input,
    output logic             push,
    output bsoc_pkg::cmd_t   cmd
);

    logic [7:0] col_reg, col_next;
    logic [7:0] pb_reg, pb_next;
    logic       rp_reg, rp_next;

    logic       accept;
    logic       ended;
    logic       is_bs;
    logic [7:0] target;
    logic       overstrike;
    logic [7:0] final_in;
    logic       rp_final;
    logic [7:0] col_base;
    bsoc_pkg::item_t final_item;

    always_comb begin
        accept     = s_valid && s_ready;
        ended      = s_end_of_input || (s_in_byte == bsoc_pkg::CH_END);
        is_bs      = !ended && (s_in_byte == bsoc_pkg::CH_BS);
        target     = (col_reg > pb_reg) ? (col_reg - pb_reg) : 8'd1;
        overstrike = target < col_reg;
        final_in   = ended ? bsoc_pkg::CH_END : s_in_byte;
        // Both the overstrike sequence and a leading line control leave the
        // translator disarmed before the byte itself goes out.
        rp_final   = (overstrike || (col_reg == 8'd1 && !ended)) ? 1'b0 : rp_reg;
        final_item.out_byte     = bsoc_pkg::translate(final_in, rp_final);
        final_item.repeat_count = 8'd1;
        col_base   = overstrike ? target : col_reg;

        cmd = '0;
        if (overstrike) begin
            cmd.items[0].out_byte     = rp_reg ? bsoc_pkg::CH_LF : bsoc_pkg::CH_CR;
            cmd.items[0].repeat_count = 8'd1;
            cmd.items[1].out_byte     = bsoc_pkg::CH_CR;
            cmd.items[1].repeat_count = 8'd1;
            if (target > 8'd1) begin
                cmd.items[2].out_byte     = bsoc_pkg::CTL_SKIP;
                cmd.items[2].repeat_count = target - 8'd1;
                cmd.items[3]              = final_item;
                cmd.last_slot             = bsoc_pkg::SLOT_W'(3);
            end else begin
                cmd.items[2]  = final_item;
                cmd.last_slot = bsoc_pkg::SLOT_W'(2);
            end
        end else if (col_reg == 8'd1 && !ended && rp_reg) begin
            cmd.items[0].out_byte     = bsoc_pkg::CH_LF;
            cmd.items[0].repeat_count = 8'd1;
            cmd.items[1]              = final_item;
            cmd.last_slot             = bsoc_pkg::SLOT_W'(1);
        end else begin
            cmd.items[0]  = final_item;
            cmd.last_slot = bsoc_pkg::SLOT_W'(0);
        end

        push     = accept && !is_bs;
        col_next = col_reg;
        pb_next  = pb_reg;
        rp_next  = rp_reg;
        if (accept && is_bs) begin
            if (pb_reg != 8'hFF) begin
                pb_next = pb_reg + 8'd1;
            end
        end else if (accept) begin
            pb_next = 8'd0;
            rp_next = (final_in == bsoc_pkg::CH_LF);
            if (ended || final_in == bsoc_pkg::CH_LF) begin
                col_next = 8'd1;
            end else if (col_base >= bsoc_pkg::COLUMN_LIMIT) begin
                col_next = bsoc_pkg::COLUMN_LIMIT;
            end else begin
                col_next = col_base + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd1;
            pb_reg  <= 8'd0;
            rp_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            pb_reg  <= pb_next;
            rp_reg  <= rp_next;
        end
    end

endmodule

[rtl/bsoc_cmd_fifo.sv]
module bsoc_cmd_fifo #(
    parameter int unsigned DEPTH = bsoc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bsoc_pkg::cmd_t wr_cmd,
    input  logic           pop,
    output bsoc_pkg::cmd_t rd_cmd,
    output logic           not_full,
    output logic           not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bsoc_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        not_full  = count_reg != CNT_W'(DEPTH);
        not_empty = count_reg != '0;
        rd_cmd    = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[rtl/bsoc_back.sv]
module bsoc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  bsoc_pkg::cmd_t head_cmd,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic [7:0]     m_repeat_count,
    output logic           m_last
);

    logic [bsoc_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] count_reg, count_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_last;

    always_comb begin
        load    = head_valid && (!valid_reg || m_ready);
        at_last = slot_reg == head_cmd.last_slot;
        pop     = load && at_last;

        slot_next  = slot_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = head_cmd.items[slot_reg].out_byte;
            count_next = head_cmd.items[slot_reg].repeat_count;
            last_next  = at_last;
            slot_next  = at_last ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_repeat_count = count_reg;
    assign m_last         = last_reg;

endmodule

[rtl/backspace_overstrike_converter_core.sv]
// Channel  Dir  Handshake        Fields                               Transaction
// s_       in   s_valid s_ready  s_in_byte s_end_of_input             one text byte or end
// m_       out  m_valid m_ready  m_out_byte m_repeat_count m_last     one printer item
//
// A backspace produces nothing. The back end emits the results of one input one at a time,
// so an input that makes k results (one to four) holds the back end for all k of them, which
// sets the sustained rate. After its input is accepted, the first result is written into the
// command queue and then loaded into the output register. Reset is synchronous and active
// low; it restores column 1, no pending backspaces and the translator disarmed. Input stalls
// only when the command queue is full.

`include "backspace_overstrike_converter_core_macros.svh"

module backspace_overstrike_converter_core #(
    parameter int unsigned QUEUE_DEPTH = bsoc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_repeat_count,
    output logic       m_last
);

    // The front end classifies each byte and, for each byte but a backspace, builds one command
    // carrying all of the result items for that byte, already translated for carriage control.
    logic           push;
    bsoc_pkg::cmd_t front_cmd;

    // The queue decouples classification from delivery, so a burst of up to
    // four results from one byte does not stall the input side.
    bsoc_pkg::cmd_t head_cmd;
    logic           head_valid;
    logic           pop;
    logic           queue_not_full;

    assign s_ready = queue_not_full;

    bsoc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .push           (push),
        .cmd            (front_cmd)
    );

    bsoc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_cmd    (front_cmd),
        .pop       (pop),
        .rd_cmd    (head_cmd),
        .not_full  (queue_not_full),
        .not_empty (head_valid)
    );

    // The back end walks the slots of the head command one per cycle, while its registered
    // output stage is empty or being taken, and retires the command after its last slot.
    bsoc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_cmd       (head_cmd),
        .head_valid     (head_valid),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_last         (m_last)
    );

    // A result never asks for zero copies.
    `BSOC_ASSERT_NOW(a_count_nonzero, aclk, aresetn, m_valid, m_repeat_count != 8'd0, "zero repeat count")

    // Only a blank run may repeat its byte.
    `BSOC_ASSERT_NOW(a_run_is_blank, aclk, aresetn, m_valid && m_repeat_count != 8'd1, m_out_byte == bsoc_pkg::CTL_SKIP, "repeated non-blank byte")

    // The end marker always closes the results of its input.
    `BSOC_ASSERT_NOW(a_end_is_last, aclk, aresetn, m_valid && m_out_byte == bsoc_pkg::CH_END, m_last, "end marker not last")

    // A backspace adds nothing to the queue, so the queue cannot fill on it.
    `BSOC_ASSERT_NEXT(a_bs_no_fill, aclk, aresetn, s_valid && s_ready && !s_end_of_input && s_in_byte == bsoc_pkg::CH_BS && !pop, s_ready == $past(s_ready), "backspace changed queue fill")

endmodule

[sim/backspace_overstrike_converter_core_checker.sv]
module backspace_overstrike_converter_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_input,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic [7:0]  m_repeat_count,
    input  logic        m_last,
    output int unsigned mismatch_count,
    output int unsigned items_outstanding,
    output int unsigned items_checked
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_count;
        logic       last;
    } printer_item_t;

    printer_item_t printer_items_due[$];
    printer_item_t line_batch[$];

    logic [7:0] print_col;
    logic [7:0] bs_count;
    logic       cr_armed;

    function automatic void queue_printer_item(input logic [7:0] b, input logic [7:0] n);
        printer_item_t it;
        it.out_byte     = b;
        it.repeat_count = n;
        it.last         = 1'b0;
        line_batch.push_back(it);
    endfunction

    // Carriage-control translation. A newline arms the translator, and the next item is mapped.
    function automatic void carriage_out(input logic [7:0] c, input bit is_ctl,
                                         input logic [7:0] n);
        if (cr_armed) begin
            cr_armed = 1'b0;
            case (c)
                bsoc_pkg::CH_LF: begin
                    queue_printer_item(bsoc_pkg::CH_LF, n);
                    cr_armed = 1'b1;
                end
                bsoc_pkg::CTL_NOSKIP: queue_printer_item(bsoc_pkg::CH_CR, n);
                bsoc_pkg::CTL_SKIP:   queue_printer_item(bsoc_pkg::CH_LF, n);
                bsoc_pkg::CTL_FORM:   queue_printer_item(bsoc_pkg::CH_FF, n);
                default:              queue_printer_item(c, n);
            endcase
        end else if (c == bsoc_pkg::CH_LF) begin
            queue_printer_item(bsoc_pkg::CH_CR, n);
            cr_armed = 1'b1;
        end else if (!(is_ctl && c == bsoc_pkg::CTL_SKIP)) begin
            queue_printer_item(c, n);
        end
    endfunction

    function automatic void convert_text_byte(input logic [7:0] b, input logic eoi);
        logic       ended;
        logic [7:0] col;
        logic [7:0] target;
        ended = eoi || (b == bsoc_pkg::CH_END);
        if (!ended && b == bsoc_pkg::CH_BS) begin
            if (bs_count != 8'hFF) begin
                bs_count = bs_count + 8'd1;
            end
            return;
        end
        line_batch.delete();
        col    = (print_col == 8'd0) ? 8'd1 : print_col;
        target = (col > bs_count) ? col - bs_count : 8'd1;
        bs_count = 8'd0;
        if (target < col) begin
            carriage_out(bsoc_pkg::CH_LF, 1'b1, 8'd1);
            carriage_out(bsoc_pkg::CTL_NOSKIP, 1'b1, 8'd1);
            if (target > 8'd1) begin
                carriage_out(bsoc_pkg::CTL_SKIP, 1'b0, target - 8'd1);
            end
            col = target;
        end else if (col == 8'd1 && !ended) begin
            carriage_out(bsoc_pkg::CTL_SKIP, 1'b1, 8'd1);
        end
        if (ended) begin
            carriage_out(bsoc_pkg::CH_END, 1'b0, 8'd1);
            print_col = 8'd1;
        end else begin
            carriage_out(b, 1'b0, 8'd1);
            if (b == bsoc_pkg::CH_LF) begin
                print_col = 8'd1;
            end else begin
                print_col = (col >= bsoc_pkg::COLUMN_LIMIT) ? bsoc_pkg::COLUMN_LIMIT
                                                            : col + 8'd1;
            end
        end
        if (line_batch.size() > 0) begin
            line_batch[line_batch.size() - 1].last = 1'b1;
        end
        foreach (line_batch[i]) begin
            printer_items_due.push_back(line_batch[i]);
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 8'h%02h, actual 8'h%02h",
                     $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        printer_item_t want;
        if (!aresetn) begin
            print_col      = 8'd1;
            bs_count       = 8'd0;
            cr_armed       = 1'b0;
            mismatch_count = 0;
            items_checked  = 0;
            printer_items_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                convert_text_byte(s_in_byte, s_end_of_input);
            end
            if (m_valid && m_ready) begin
                items_checked++;
                if (printer_items_due.size() == 0) begin
                    $display("%0t: unexpected printer transaction, expected none, actual %02h x%0d last %0b",
                             $time, m_out_byte, m_repeat_count, m_last);
                    mismatch_count++;
                end else begin
                    want = printer_items_due.pop_front();
                    check_field("out_byte", want.out_byte, m_out_byte);
                    check_field("repeat_count", want.repeat_count, m_repeat_count);
                    check_field("last", {7'd0, want.last}, {7'd0, m_last});
                end
            end
        end
        items_outstanding = printer_items_due.size();
    end

endmodule

[sim/backspace_overstrike_converter_core_tb.sv]
module backspace_overstrike_converter_core_tb;

    // Least number of random input transactions after the directed part and the saturation run.
    localparam int unsigned RANDOM_ITEMS = 45;
    // Cycles without any transaction on either channel before the run is declared hung.
    localparam int unsigned IDLE_LIMIT   = 1000;
    // Cycles to wait once all predicted results are in, to catch stray late transactions.
    localparam int unsigned DRAIN_CYCLES = 8;

    // Receiver stall patterns: always ready, fair coin, mostly stalled, and toggling.
    typedef enum int unsigned {RX_OPEN, RX_COIN, RX_STINGY, RX_TOGGLE} rx_mode_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_input;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [7:0] m_repeat_count;
    logic       m_last;

    int unsigned mismatch_count;
    int unsigned items_outstanding;
    int unsigned items_checked;
    int unsigned bytes_sent;
    int unsigned backspaces_sent;
    int unsigned ends_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;

    backspace_overstrike_converter_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_last         (m_last)
    );

    // The checker sees both channels, predicts every printer transaction and compares them.
    backspace_overstrike_converter_core_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_end_of_input    (s_end_of_input),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_repeat_count    (m_repeat_count),
        .m_last            (m_last),
        .mismatch_count    (mismatch_count),
        .items_outstanding (items_outstanding),
        .items_checked     (items_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver switches between stall patterns of random length. Long open stretches
    // let the command queue drain, while the stingy pattern fills it and stalls the input.
    initial begin
        rx_mode_t    mode;
        int unsigned run;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            run  = $urandom_range(4, 40);
            repeat (run) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 0);
                    RX_STINGY: m_ready <= ($urandom_range(0, 5) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Any transaction on either channel counts as progress. If nothing moves for too
    // long, the block is hung and the run ends here.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d printer items still due",
                     $time, IDLE_LIMIT, items_outstanding);
            $display("backspace_overstrike_converter_core_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The sender keeps valid low during the hold-off.
    task automatic hold_off(input int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Presents one byte at the falling edge and waits for the transaction. Between bursts
    // of random length the sender takes a random break; a break of zero keeps valid high.
    task automatic drive_byte(input logic [7:0] b, input logic eoi);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
        if (eoi || b == bsoc_pkg::CH_END) begin
            ends_sent++;
        end else if (b == bsoc_pkg::CH_BS) begin
            backspaces_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_off($urandom_range(0, 8));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // The sender stops until every predicted printer item has been seen.
    task automatic wait_for_printer();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (items_outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic drive_printables(input int unsigned n);
        repeat (n) begin
            drive_byte(printable_byte(), 1'b0);
        end
    endtask

    task automatic drive_backspaces(input int unsigned n);
        repeat (n) begin
            drive_byte(bsoc_pkg::CH_BS, 1'b0);
        end
    endtask

    // One random passage of text. Most passages are well formed lines, overstrikes and
    // wide blank runs; the rest are end markers, raw noise over all byte values and runs of newlines.
    task automatic drive_passage();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 19);
        n    = $urandom_range(1, 8);
        if (roll < 8) begin
            drive_printables($urandom_range(1, 20));
            if ($urandom_range(0, 9) < 7) begin
                drive_byte(bsoc_pkg::CH_LF, 1'b0);
            end
        end else if (roll < 13) begin
            drive_printables(n);
            drive_backspaces($urandom_range(1, n + 2));
            drive_printables($urandom_range(1, 4));
        end else if (roll < 15) begin
            if ($urandom_range(0, 1) == 0) begin
                drive_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                drive_byte(bsoc_pkg::CH_END, 1'b0);
            end
        end else if (roll < 18) begin
            repeat ($urandom_range(1, 10)) begin
                drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end else if (roll < 19) begin
            drive_printables($urandom_range(30, 90));
            drive_backspaces($urandom_range(1, 6));
            drive_byte(printable_byte(), 1'b0);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                drive_byte(bsoc_pkg::CH_LF, 1'b0);
            end
        end
    endtask

    initial begin
        int unsigned random_start;
        s_valid         = 1'b0;
        s_in_byte       = 8'd0;
        s_end_of_input  = 1'b0;
        aresetn         = 1'b0;
        idle_cycles     = 0;
        bytes_sent      = 0;
        backspaces_sent = 0;
        ends_sent       = 0;
        burst_left      = 6;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The first byte of the stream gets a blank line control that is
        // dropped, since no carriage return precedes it.
        drive_byte("A", 1'b0);
        // A single backspace at column 2 pulls the target to column 1: the overstrike
        // has a CR and a '+' control but no blank run.
        drive_byte(bsoc_pkg::CH_BS, 1'b0);
        drive_byte("B", 1'b0);
        // A data blank is never dropped.
        drive_byte(" ", 1'b0);
        drive_byte("C", 1'b0);
        // Two backspaces from column 4 give a blank run of one, so four printer items.
        drive_backspaces(2);
        drive_byte("_", 1'b0);
        // A newline arms the translator; the next line's blank control becomes LF.
        drive_byte(bsoc_pkg::CH_LF, 1'b0);
        drive_byte(" ", 1'b0);
        // A blank line: the second newline keeps the translator armed.
        drive_byte(bsoc_pkg::CH_LF, 1'b0);
        drive_byte(bsoc_pkg::CH_LF, 1'b0);
        drive_byte("1", 1'b0);
        drive_byte(8'hFF, 1'b0);
        drive_byte(8'h00, 1'b0);
        // End of input flushes a pending overstrike first and ignores the byte.
        drive_byte(bsoc_pkg::CH_BS, 1'b0);
        drive_byte(8'h55, 1'b1);
        // The in-band end marker, then end of input carrying a backspace code.
        drive_byte(bsoc_pkg::CH_END, 1'b0);
        drive_byte(bsoc_pkg::CH_BS, 1'b1);
        // End right after a newline passes the marker through the armed translator.
        drive_byte(bsoc_pkg::CH_LF, 1'b0);
        drive_byte(bsoc_pkg::CH_END, 1'b0);
        // Backspaces at column 1 on a fresh stream cannot pull the target back.
        drive_byte(bsoc_pkg::CH_BS, 1'b0);
        drive_byte("x", 1'b0);
        drive_byte(bsoc_pkg::CH_LF, 1'b0);

        // Let the printer side run dry before the long line.
        wait_for_printer();

        // Saturation: the column stops at its limit, and three backspaces from there
        // need a blank run of 251.
        drive_printables(256);
        drive_backspaces(3);
        drive_byte("#", 1'b0);
        drive_byte(bsoc_pkg::CH_LF, 1'b0);
        wait_for_printer();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_ITEMS) begin
            drive_passage();
        end

        // All input is in: wait for the predicted items, then for stray late transactions.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (items_outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d text transactions (%0d backspaces, %0d ends of input) in bursts.",
                 bytes_sent, backspaces_sent, ends_sent);
        $display("Compared %0d printer transactions, %0d mismatches, column saturation included.",
                 items_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("backspace_overstrike_converter_core_tb: clean");
        end else begin
            $display("backspace_overstrike_converter_core_tb: errors");
        end
        $finish;
    end

endmodule
